>>> hw/rtl/format_directive_formatter_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the format directive formatter
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FORMAT_DIRECTIVE_FORMATTER_UNIT_DEFINES_SVH
`define FORMAT_DIRECTIVE_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is applied
`define FDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, masked while reset is applied
`define FDF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also covers reset itself
`define FDF_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

>>> hw/rtl/fdf_pkg.sv
// ----------------------------------------------------------------------------
// fdf_pkg
// Types, character codes and microcode encodings of the formatter.
// ----------------------------------------------------------------------------
package fdf_pkg;

  // ASCII codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [7:0] CH_D_LOWER = 8'h64;
  localparam logic [7:0] CH_X_LOWER = 8'h78;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] fdf_step_t;

  // Program addresses
  localparam fdf_step_t ST_FETCH    = 4'd0;
  localparam fdf_step_t ST_CHAR     = 4'd1;
  localparam fdf_step_t ST_END      = 4'd2;
  localparam fdf_step_t ST_HEX      = 4'd3;
  localparam fdf_step_t ST_DEC      = 4'd4;
  localparam fdf_step_t ST_MINUS    = 4'd5;
  localparam fdf_step_t ST_DABBLE   = 4'd6;
  localparam fdf_step_t ST_DIGIT    = 4'd7;
  localparam fdf_step_t ST_RETURN   = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOAD_HEX,
    OP_LOAD_DEC,
    OP_DABBLE,
    OP_SHIFT_DIG
  } fdf_op_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_CHAR,
    EM_MINUS,
    EM_DIGIT,
    EM_END
  } fdf_emit_t;

  typedef enum logic [2:0] {
    CD_NEVER,
    CD_ALWAYS,
    CD_DISPATCH,
    CD_NOT_NEG,
    CD_BIT_MORE,
    CD_DIG_MORE
  } fdf_cond_t;

  typedef enum logic [2:0] {
    CL_END,
    CL_SETPCT,
    CL_CHAR,
    CL_HEX,
    CL_DEC
  } fdf_class_t;

  // One control word of the program
  typedef struct packed {
    fdf_op_t   op;
    fdf_emit_t emit;
    fdf_cond_t cond;
    fdf_step_t target;
  } fdf_uword_t;

  // Sequencer to datapath
  typedef struct packed {
    fdf_uword_t uw;
    logic       advance;
    logic       fire;
  } fdf_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    fdf_class_t fmt_class;
    logic       neg;
    logic       bit_more;
    logic       dig_more;
    logic       lead_zero;
    logic       slot_free;
  } fdf_status_t;

  // Map a digit value to lower-case ASCII
  function automatic logic [7:0] ascii_digit(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = CH_A_LOWER + {4'd0, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/format_directive_formatter_unit.sv
// A result is captured in the output register at the end of the step that issues it.
// An ordinary character, %% or end of string is dispatched, then emitted; a lone '%' is
// only dispatched. %d first emits any sign and runs the one-bit-a-cycle BCD converter;
// %x and %d then step through NDIG digits (NDIG = 10 when ARG_BITS is 32), one a cycle
// while the output is free. Reset (synchronous, active low) clears the step counter,
// pending percent, count and output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// format_directive_formatter_unit
// Microcoded printf-style formatter for %d, %x and %% with a character count.
// ----------------------------------------------------------------------------
module format_directive_formatter_unit import fdf_pkg::*; #(
  parameter int ARG_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_fmt_char,
  input  logic [ARG_BITS-1:0] in_arg_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_last,
  output logic                out_done_res,
  output logic [31:0]         out_char_count
);

  fdf_step_t   step_r;
  fdf_step_t   step_nxt;
  fdf_step_t   disp_target;
  fdf_uword_t  uword;
  fdf_status_t status;
  fdf_ctl_t    ctl;
  logic        emit_now;
  logic        cond_true;

  fdf_ucode_rom u_rom (
    .step        (step_r),
    .fmt_class   (status.fmt_class),
    .uword       (uword),
    .disp_target (disp_target)
  );

  fdf_datapath #(
    .ARG_BITS (ARG_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fmt_char    (in_fmt_char),
    .in_arg_word    (in_arg_word),
    .ctl            (ctl),
    .out_ready      (out_ready),
    .status         (status),
    .out_valid      (out_valid),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_done_res   (out_done_res),
    .out_char_count (out_char_count)
  );

  // Take an item only in the fetch step
  assign in_ready = (uword.cond == CD_DISPATCH);

  // Drop leading zeros without waiting on the output register
  assign emit_now = (uword.emit != EM_NONE) &&
                    !((uword.emit == EM_DIGIT) && status.lead_zero);

  // Evaluate the jump condition
  always_comb begin
    unique case (uword.cond)
      CD_NEVER:    cond_true = 1'b0;
      CD_ALWAYS:   cond_true = 1'b1;
      CD_DISPATCH: cond_true = 1'b1;
      CD_NOT_NEG:  cond_true = !status.neg;
      CD_BIT_MORE: cond_true = status.bit_more;
      CD_DIG_MORE: cond_true = status.dig_more;
      default:     cond_true = 1'b0;
    endcase
  end

  // Hold on a stalled step, otherwise jump or advance
  always_comb begin
    ctl.uw = uword;
    if (uword.cond == CD_DISPATCH) begin
      ctl.advance = in_valid;
    end else begin
      ctl.advance = !emit_now || status.slot_free;
    end
    ctl.fire = emit_now && status.slot_free;

    step_nxt = step_r;
    if (ctl.advance) begin
      if (uword.cond == CD_DISPATCH) begin
        step_nxt = disp_target;
      end else if (cond_true) begin
        step_nxt = uword.target;
      end else begin
        step_nxt = step_r + fdf_step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> hw/rtl/fdf_ucode_rom.sv
// ----------------------------------------------------------------------------
// fdf_ucode_rom
// Control store and directive dispatch table of the formatter sequencer.
// ----------------------------------------------------------------------------
module fdf_ucode_rom import fdf_pkg::*; (
  input  fdf_step_t  step,
  input  fdf_class_t fmt_class,
  output fdf_uword_t uword,
  output fdf_step_t  disp_target
);

  // Control words, one per program step
  always_comb begin
    uword = '{op: OP_NONE, emit: EM_NONE, cond: CD_ALWAYS, target: ST_FETCH};
    unique case (step)
      ST_FETCH:  uword = '{op: OP_LOAD,      emit: EM_NONE,  cond: CD_DISPATCH,
                          target: ST_FETCH};
      ST_CHAR:   uword = '{op: OP_NONE,      emit: EM_CHAR,  cond: CD_ALWAYS,
                          target: ST_FETCH};
      ST_END:    uword = '{op: OP_NONE,      emit: EM_END,   cond: CD_ALWAYS,
                          target: ST_FETCH};
      ST_HEX:    uword = '{op: OP_LOAD_HEX,  emit: EM_NONE,  cond: CD_ALWAYS,
                          target: ST_DIGIT};
      ST_DEC:    uword = '{op: OP_LOAD_DEC,  emit: EM_NONE,  cond: CD_NOT_NEG,
                          target: ST_DABBLE};
      ST_MINUS:  uword = '{op: OP_NONE,      emit: EM_MINUS, cond: CD_NEVER,
                          target: ST_FETCH};
      ST_DABBLE: uword = '{op: OP_DABBLE,    emit: EM_NONE,  cond: CD_BIT_MORE,
                          target: ST_DABBLE};
      ST_DIGIT:  uword = '{op: OP_SHIFT_DIG, emit: EM_DIGIT, cond: CD_DIG_MORE,
                          target: ST_DIGIT};
      ST_RETURN: uword = '{op: OP_NONE,      emit: EM_NONE,  cond: CD_ALWAYS,
                          target: ST_FETCH};
      default:   uword = '{op: OP_NONE,      emit: EM_NONE,  cond: CD_ALWAYS,
                          target: ST_FETCH};
    endcase
  end

  // Entry point per kind of format character
  always_comb begin
    unique case (fmt_class)
      CL_END:    disp_target = ST_END;
      CL_SETPCT: disp_target = ST_FETCH;
      CL_CHAR:   disp_target = ST_CHAR;
      CL_HEX:    disp_target = ST_HEX;
      CL_DEC:    disp_target = ST_DEC;
      default:   disp_target = ST_FETCH;
    endcase
  end

endmodule

>>> hw/rtl/fdf_datapath.sv
// ----------------------------------------------------------------------------
// fdf_datapath
// Character latch, binary-to-BCD converter, digit shifter, character
// counter and output register, all driven by the current control word.
// ----------------------------------------------------------------------------
module fdf_datapath import fdf_pkg::*; #(
  parameter int ARG_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_fmt_char,
  input  logic [ARG_BITS-1:0] in_arg_word,
  input  fdf_ctl_t            ctl,
  input  logic                out_ready,
  output fdf_status_t         status,
  output logic                out_valid,
  output logic [7:0]          out_char,
  output logic                out_last,
  output logic                out_done_res,
  output logic [31:0]         out_char_count
);

  localparam int HEX_DIGITS = (ARG_BITS + 3) / 4;
  localparam int DEC_DIGITS = ((ARG_BITS * 1233) >> 12) + 1;
  localparam int NDIG       = (HEX_DIGITS > DEC_DIGITS) ? HEX_DIGITS : DEC_DIGITS;
  localparam int DIG_W      = NDIG * 4;
  localparam int BCNT_W     = $clog2(ARG_BITS + 1);
  localparam int DCNT_W     = $clog2(NDIG + 1);

  logic [7:0]          char_r;
  logic [ARG_BITS-1:0] arg_r;
  logic [DIG_W-1:0]    dig_r;
  logic [DIG_W-1:0]    dig_adj;
  logic [BCNT_W-1:0]   bcnt_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic                started_r;
  logic                pending_r;
  logic [31:0]         count_r;
  logic                out_valid_r;
  logic [7:0]          out_char_r;
  logic                out_last_r;
  logic                out_done_r;
  logic [31:0]         out_count_r;
  logic [3:0]          top_nib;
  logic                dig_last;
  logic                neg;
  fdf_class_t          fmt_class;
  logic [7:0]          emit_char;
  logic                emit_last;

  // Classify the offered format character against the pending percent
  always_comb begin
    if (in_fmt_char == CH_NUL) begin
      fmt_class = CL_END;
    end else if (pending_r) begin
      if (in_fmt_char == CH_X_LOWER) begin
        fmt_class = CL_HEX;
      end else if (in_fmt_char == CH_D_LOWER) begin
        fmt_class = CL_DEC;
      end else begin
        fmt_class = CL_CHAR;
      end
    end else if (in_fmt_char == CH_PERCENT) begin
      fmt_class = CL_SETPCT;
    end else begin
      fmt_class = CL_CHAR;
    end
  end

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    logic [3:0] nib;
    for (int i = 0; i < NDIG; i++) begin
      nib = dig_r[i*4 +: 4];
      dig_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  assign top_nib  = dig_r[DIG_W-1 -: 4];
  assign dig_last = (dcnt_r == DCNT_W'(1));
  assign neg      = arg_r[ARG_BITS-1];

  assign status.fmt_class = fmt_class;
  assign status.neg       = neg;
  assign status.bit_more  = (bcnt_r != BCNT_W'(1));
  assign status.dig_more  = !dig_last;
  assign status.lead_zero = !started_r && (top_nib == 4'd0) && !dig_last;
  assign status.slot_free = !out_valid_r || out_ready;

  // Select the character and last flag of the result being issued
  always_comb begin
    unique case (ctl.uw.emit)
      EM_CHAR: begin
        emit_char = char_r;
        emit_last = 1'b1;
      end
      EM_MINUS: begin
        emit_char = CH_MINUS;
        emit_last = 1'b0;
      end
      EM_DIGIT: begin
        emit_char = ascii_digit(top_nib);
        emit_last = dig_last;
      end
      EM_END: begin
        emit_char = CH_NUL;
        emit_last = 1'b1;
      end
      default: begin
        emit_char = CH_NUL;
        emit_last = 1'b0;
      end
    endcase
  end

  // Control state: pending percent, count, leading-zero flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      count_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.advance && ctl.uw.op == OP_LOAD) begin
        pending_r <= (fmt_class == CL_SETPCT);
      end
      if (ctl.advance && (ctl.uw.op == OP_LOAD_HEX || ctl.uw.op == OP_LOAD_DEC)) begin
        started_r <= 1'b0;
      end else if (ctl.advance && ctl.uw.op == OP_SHIFT_DIG && top_nib != 4'd0) begin
        started_r <= 1'b1;
      end
      if (ctl.fire) begin
        count_r <= (ctl.uw.emit == EM_END) ? 32'd0 : count_r + 32'd1;
      end
      if (ctl.fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers, advanced by the control word's operation
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      case (ctl.uw.op)
        OP_LOAD: begin
          char_r <= in_fmt_char;
          arg_r  <= in_arg_word;
        end
        OP_LOAD_HEX: begin
          dig_r  <= DIG_W'(arg_r);
          dcnt_r <= DCNT_W'(NDIG);
        end
        OP_LOAD_DEC: begin
          arg_r  <= neg ? (~arg_r + ARG_BITS'(1)) : arg_r;
          dig_r  <= '0;
          bcnt_r <= BCNT_W'(ARG_BITS);
          dcnt_r <= DCNT_W'(NDIG);
        end
        OP_DABBLE: begin
          dig_r  <= {dig_adj[DIG_W-2:0], arg_r[ARG_BITS-1]};
          arg_r  <= {arg_r[ARG_BITS-2:0], 1'b0};
          bcnt_r <= bcnt_r - BCNT_W'(1);
        end
        OP_SHIFT_DIG: begin
          dig_r  <= {dig_r[DIG_W-5:0], 4'd0};
          dcnt_r <= dcnt_r - DCNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      out_char_r  <= emit_char;
      out_last_r  <= emit_last;
      out_done_r  <= (ctl.uw.emit == EM_END);
      out_count_r <= (ctl.uw.emit == EM_END) ? count_r : count_r + 32'd1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_last       = out_last_r;
  assign out_done_res   = out_done_r;
  assign out_char_count = out_count_r;

endmodule

>>> hw/rtl/fdf_checker.sv
// ----------------------------------------------------------------------------
// fdf_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "format_directive_formatter_unit_defines.svh"

module fdf_checker #(
  parameter int ARG_BITS = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [7:0]          in_fmt_char,
  input logic [ARG_BITS-1:0] in_arg_word,
  input logic                out_valid,
  input logic                out_ready,
  input logic [7:0]          out_char,
  input logic                out_last,
  input logic                out_done_res,
  input logic [31:0]         out_char_count
);

  // Hold an offered format item unchanged until it is taken
  `FDF_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_fmt_char) && $stable(in_arg_word))

  // Hold a stalled result unchanged
  `FDF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last) && $stable(out_done_res) && $stable(out_char_count))

  // End-of-string report closes its item and carries a zero character
  `FDF_ASSERT_IMP(a_done_shape, out_valid && out_done_res, out_last && (out_char == 8'h00))

  // Leave reset ready for a format character with no result shown
  `FDF_ASSERT_RST(a_reset_idle, !rst_n, !out_valid && in_ready)

endmodule

bind format_directive_formatter_unit fdf_checker #(.ARG_BITS(ARG_BITS)) u_fdf_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: format directive formatter testbench
// Feeds format bytes with argument words over a valid/ready channel, rebuilds
// the expected character stream (%d, %x, %%, copied bytes, end-of-string count)
// in a local formatter, and compares every emitted item field by field under
// random input gaps and output stalls in most of the run.
// ----------------------------------------------------------------------------
module tb_top;
  import fdf_pkg::*;

  localparam logic [7:0] CH_S_LOWER = 8'h73;
  localparam logic [7:0] CH_A_UPPER = 8'h41;
  localparam logic [7:0] CH_TOP     = 8'hFF;
  localparam logic [7:0] CH_LOW     = 8'h01;
  localparam int RANDOM_ITEMS = 375;
  localparam int SHOW_LIMIT   = 10;

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic        done;
    logic [31:0] count;
  } fmt_result_t;

  typedef enum int {
    TK_PLAIN,
    TK_DEC,
    TK_HEX,
    TK_PCT,
    TK_UNKNOWN,
    TK_PCT_END
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_fmt_char = 8'd0;
  logic [31:0] in_arg_word = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        out_last;
  logic        out_done_res;
  logic [31:0] out_char_count;

  // Local formatter state
  logic        pct_armed;
  logic [31:0] chars_so_far;
  fmt_result_t pending_chars[$];

  // Run control and tallies
  bit in_gaps_on;
  bit out_stalls_on;
  int items_sent;
  int results_seen;
  int strings_closed;
  int mismatches;

  format_directive_formatter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_fmt_char    (in_fmt_char),
    .in_arg_word    (in_arg_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last       (out_last),
    .out_done_res   (out_done_res),
    .out_char_count (out_char_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expand one format byte into the characters it emits
  task automatic format_item(input logic [7:0] fc, input logic [31:0] arg);
    logic [7:0]  txt [0:11];
    logic [3:0]  dig [0:9];
    logic [31:0] mag;
    int          n;
    int          nd;
    fmt_result_t r;
    n = 0;
    if (fc == CH_NUL) begin
      r.ch = CH_NUL;
      r.last = 1'b1;
      r.done = 1'b1;
      r.count = chars_so_far;
      pending_chars.push_back(r);
      pct_armed = 1'b0;
      chars_so_far = 32'd0;
      return;
    end
    if (pct_armed) begin
      pct_armed = 1'b0;
      if (fc == CH_D_LOWER || fc == CH_X_LOWER) begin
        mag = arg;
        if (fc == CH_D_LOWER && arg[31]) begin
          txt[n] = CH_MINUS;
          n++;
          mag = -arg;
        end
        nd = 0;
        do begin
          if (fc == CH_D_LOWER) begin
            dig[nd] = 4'(mag % 10);
            mag = mag / 10;
          end else begin
            dig[nd] = mag[3:0];
            mag = mag >> 4;
          end
          nd++;
        end while (mag != 32'd0);
        while (nd > 0) begin
          nd--;
          txt[n] = (dig[nd] < 4'd10) ? CH_ZERO + 8'(dig[nd])
                                     : CH_A_LOWER + 8'(dig[nd]) - 8'd10;
          n++;
        end
      end else begin
        // Percent sign, or an unknown directive copied as a plain byte
        txt[n] = fc;
        n++;
      end
    end else if (fc == CH_PERCENT) begin
      pct_armed = 1'b1;
    end else begin
      txt[n] = fc;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      chars_so_far = chars_so_far + 32'd1;
      r.ch = txt[i];
      r.last = (i == n - 1);
      r.done = 1'b0;
      r.count = chars_so_far;
      pending_chars.push_back(r);
    end
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!in_gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_arg();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        return 32'h8000_0000;
      end
      1: begin
        return 32'hFFFF_FFFF;
      end
      2: begin
        return 32'(-$urandom_range(1, 999));
      end
      3, 4: begin
        return 32'($urandom_range(0, 999));
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Send one item: optional gap, then hold valid until accepted
  task automatic send_item(input logic [7:0] fc, input logic [31:0] arg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_fmt_char <= fc;
    in_arg_word <= arg;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    format_item(fc, arg);
    items_sent++;
  endtask

  // Hold the sender until every expected item has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_plain_chars();
    send_item(CH_TOP, 32'h0000_0000);
    send_item(CH_LOW, 32'hFFFF_FFFF);
    send_item(CH_A_UPPER, $urandom);
    send_item(CH_NUL, $urandom);
  endtask

  task automatic test_directives();
    send_item(CH_PERCENT, $urandom);
    send_item(CH_PERCENT, $urandom);
    send_item(CH_PERCENT, 32'd0);
    send_item(CH_D_LOWER, 32'hFFFF_FFFF);
    send_item(CH_PERCENT, 32'd0);
    send_item(CH_D_LOWER, 32'h8000_0000);
    send_item(CH_PERCENT, 32'd0);
    send_item(CH_D_LOWER, 32'h7FFF_FFFF);
    send_item(CH_PERCENT, 32'd0);
    send_item(CH_X_LOWER, 32'h0000_0000);
    send_item(CH_PERCENT, 32'd0);
    send_item(CH_X_LOWER, 32'hFFFF_FFFF);
    send_item(CH_NUL, 32'd0);
  endtask

  task automatic test_special_cases();
    // Unsupported string directive falls back to a plain byte
    send_item(CH_PERCENT, $urandom);
    send_item(CH_S_LOWER, $urandom);
    // Percent dropped by end of string
    send_item(CH_PERCENT, $urandom);
    send_item(CH_NUL, $urandom);
    // Empty string reports zero
    send_item(CH_NUL, $urandom);
  endtask

  task automatic send_token(input token_t tk);
    logic [7:0] c;
    case (tk)
      TK_PLAIN: begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_PERCENT);
        send_item(c, $urandom);
      end
      TK_DEC: begin
        send_item(CH_PERCENT, $urandom);
        send_item(CH_D_LOWER, rand_arg());
      end
      TK_HEX: begin
        send_item(CH_PERCENT, $urandom);
        send_item(CH_X_LOWER, rand_arg());
      end
      TK_PCT: begin
        send_item(CH_PERCENT, $urandom);
        send_item(CH_PERCENT, $urandom);
      end
      TK_UNKNOWN: begin
        do c = 8'($urandom_range(1, 255));
        while (c == CH_PERCENT || c == CH_D_LOWER || c == CH_X_LOWER);
        send_item(CH_PERCENT, $urandom);
        send_item(c, $urandom);
      end
      default: begin
        send_item(CH_PERCENT, $urandom);
      end
    endcase
  endtask

  // Mostly well-formed strings, some raw byte noise
  task automatic test_random_strings(input int budget);
    int stop_at;
    int ntok;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        ntok = $urandom_range(1, 8);
        repeat (ntok) send_item(8'($urandom), $urandom);
      end else begin
        ntok = $urandom_range(1, 6);
        for (int i = 0; i < ntok; i++) begin
          if (i == ntok - 1 && $urandom_range(0, 9) == 0) begin
            send_token(TK_PCT_END);
          end else begin
            send_token(token_t'($urandom_range(TK_PLAIN, TK_UNKNOWN)));
          end
        end
      end
      send_item(CH_NUL, $urandom);
    end
  endtask

  // Random output stalls, mostly short
  initial begin : ready_gen
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (out_stalls_on && $urandom_range(0, 99) < 25) begin
        hold = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 30);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input fmt_result_t want);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) begin
      $display("mismatch at %0t: char %h/%h last %b/%b done %b/%b count %0d/%0d (exp/got)",
               $time, want.ch, out_char, want.last, out_last, want.done, out_done_res,
               want.count, out_char_count);
    end
  endtask

  // Compare each accepted item with the oldest expectation
  always @(posedge clk) begin : check_out
    fmt_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
          $display("unexpected item at %0t: char %h last %b done %b count %0d",
                   $time, out_char, out_last, out_done_res, out_char_count);
        end
      end else begin
        want = pending_chars.pop_front();
        if (want.done) begin
          strings_closed++;
        end
        if (out_char !== want.ch || out_last !== want.last ||
            out_done_res !== want.done || out_char_count !== want.count) begin
          report_mismatch(want);
        end
      end
    end
  end

  initial begin : run_limit
    #20_000_000;
    $display("timeout with %0d items still expected", pending_chars.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : main
    pct_armed = 1'b0;
    chars_so_far = 32'd0;
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_chars();
    test_directives();
    test_special_cases();
    test_random_strings(RANDOM_ITEMS / 2);
    wait_drained();
    // Back-to-back stretch without idling on either side
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    test_random_strings(RANDOM_ITEMS / 5);
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    test_random_strings(RANDOM_ITEMS - RANDOM_ITEMS / 2 - RANDOM_ITEMS / 5);

    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (pending_chars.size() != 0) begin
      mismatches++;
    end
    $display("sent %0d format bytes, checked %0d output items over %0d strings",
             items_sent, results_seen, strings_closed);
    $display("covered plain bytes, %%d, %%x, %%%%, unknown directives, early end, %0d errors",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fdf_pkg.sv
hw/rtl/fdf_ucode_rom.sv
hw/rtl/fdf_datapath.sv
hw/rtl/format_directive_formatter_unit.sv
hw/rtl/fdf_checker.sv
sim/tb_top.sv
